// ----- rtl/delimiter_or_length_framer_assert.svh -----
// Assertion macros for the delimiter or length framer checks.
`ifndef DELIMITER_OR_LENGTH_FRAMER_ASSERT_SVH
`define DELIMITER_OR_LENGTH_FRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DLF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define DLF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dlf_pkg.sv -----
// Shared types and constants of the delimiter or length framer.
`default_nettype none
package dlf_pkg;

   localparam int MAX_DELIM_LEN = 8;
   localparam int BYTE_W        = 8;
   localparam int WIN_W         = MAX_DELIM_LEN * BYTE_W;
   localparam int DLEN_W        = 4;
   localparam int FILL_W        = 16;
   localparam int CSR_IDX_W     = 3;

   localparam logic [FILL_W-1:0] FILL_MAX        = '1;
   localparam logic [WIN_W-1:0]  DELIM_BYTES_RST = WIN_W'(64'h0A0D);
   localparam logic [DLEN_W-1:0] DELIM_LEN_RST   = DLEN_W'(2);
   localparam logic [FILL_W-1:0] CONTENT_LEN_RST = FILL_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_MODE  = 3'd0,
      CSR_DELIM_BYTES = 3'd1,
      CSR_DELIM_LEN   = 3'd2,
      CSR_CONTENT_LEN = 3'd3
   } csr_idx_type;

   typedef enum logic {
      MODE_DELIM = 1'b0,
      MODE_FIXED = 1'b1
   } frame_mode_type;

   typedef struct packed {
      frame_mode_type      frame_mode;
      logic [WIN_W-1:0]    delim_bytes;
      logic [DLEN_W-1:0]   delim_len;
      logic [FILL_W-1:0]   content_len;
   } cfg_type;

endpackage
`default_nettype wire

// ----- rtl/dlf_csr.sv -----
// Configuration registers and the progress-clear pulse.
`default_nettype none
module dlf_csr (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_valid,
   input  wire [dlf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [dlf_pkg::WIN_W-1:0]     csr_data,
   output dlf_pkg::cfg_type             cfg,
   output logic                         clear
);
   import dlf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      clear  = 1'b0;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_FRAME_MODE: begin
               cfg_in.frame_mode = frame_mode_type'(csr_data[0]);
               clear = 1'b1;
            end
            CSR_DELIM_BYTES: begin
               cfg_in.delim_bytes = csr_data;
               clear = 1'b1;
            end
            CSR_DELIM_LEN: begin
               cfg_in.delim_len = csr_data[DLEN_W-1:0];
               clear = 1'b1;
            end
            CSR_CONTENT_LEN: begin
               cfg_in.content_len = csr_data[FILL_W-1:0];
               clear = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_mode  <= MODE_DELIM;
         cfg_ff.delim_bytes <= DELIM_BYTES_RST;
         cfg_ff.delim_len   <= DELIM_LEN_RST;
         cfg_ff.content_len <= CONTENT_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- rtl/dlf_match.sv -----
// Delimiter window compare: all lengths in parallel, then select.
`default_nettype none
module dlf_match (
   input  wire [dlf_pkg::WIN_W-1:0]  window,
   input  wire [dlf_pkg::WIN_W-1:0]  delim_bytes,
   input  wire [dlf_pkg::DLEN_W-1:0] delim_len,
   input  wire [dlf_pkg::FILL_W-1:0] fill,
   output logic                      hit
);
   import dlf_pkg::*;

   localparam int SEL_W = $clog2(MAX_DELIM_LEN) > 0 ? $clog2(MAX_DELIM_LEN) : 1;

   logic [MAX_DELIM_LEN-1:0] hit_vec;
   logic [DLEN_W-1:0]        len_used;
   logic [SEL_W-1:0]         sel;

   // zero counts as one, above the window saturates
   always_comb begin
      if (delim_len == '0) begin
         len_used = DLEN_W'(1);
      end else if (delim_len > DLEN_W'(MAX_DELIM_LEN)) begin
         len_used = DLEN_W'(MAX_DELIM_LEN);
      end else begin
         len_used = delim_len;
      end
      sel = SEL_W'(len_used - DLEN_W'(1));
   end

   // hit_vec[k]: delimiter of k+1 bytes ends at the newest byte
   always_comb begin
      for (int k = 0; k < MAX_DELIM_LEN; k++) begin
         hit_vec[k] = 1'b1;
         for (int i = 0; i < MAX_DELIM_LEN; i++) begin
            if (i <= k) begin
               if (delim_bytes[BYTE_W*i +: BYTE_W] != window[BYTE_W*(k-i) +: BYTE_W]) begin
                  hit_vec[k] = 1'b0;
               end
            end
         end
      end
   end

   assign hit = hit_vec[sel] && (fill >= FILL_W'(len_used));

endmodule
`default_nettype wire

// ----- rtl/dlf_core.sv -----
// Input stage, frame tracking state and result register.
`default_nettype none
module dlf_core (
   input  wire                        clock,
   input  wire                        reset,
   input  dlf_pkg::cfg_type           cfg,
   input  wire                        clear,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire [dlf_pkg::BYTE_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [dlf_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                       rsp_tlast
);
   import dlf_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_last_ff;
   logic [WIN_W-1:0]  recent_ff, recent_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              out_free;
   logic              adv;
   logic              req_acc;
   logic [WIN_W-1:0]  window;
   logic [FILL_W-1:0] fill_inc;
   logic [FILL_W-1:0] need;
   logic              delim_hit;
   logic              done;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign adv        = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_acc    = req_tvalid && req_tready;

   assign window   = {recent_ff[WIN_W-BYTE_W-1:0], s1_byte_ff};
   assign fill_inc = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + FILL_W'(1);
   assign need     = (cfg.content_len == '0) ? FILL_W'(1) : cfg.content_len;

   dlf_match u_match (
      .window      (window),
      .delim_bytes (cfg.delim_bytes),
      .delim_len   (cfg.delim_len),
      .fill        (fill_inc),
      .hit         (delim_hit)
   );

   assign done = (cfg.frame_mode == MODE_FIXED) ? (fill_inc >= need) : delim_hit;

   always_comb begin
      s1_valid_in  = req_acc || (s1_valid_ff && !adv);
      out_valid_in = adv || (out_valid_ff && !rsp_tready);
      recent_in    = recent_ff;
      fill_in      = fill_ff;
      if (clear) begin
         recent_in = '0;
         fill_in   = '0;
      end else if (adv) begin
         recent_in = window;
         fill_in   = done ? '0 : fill_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         recent_ff    <= '0;
         fill_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         recent_ff    <= recent_in;
         fill_ff      <= fill_in;
      end
      if (req_acc) begin
         s1_byte_ff <= req_tdata;
      end
      if (adv) begin
         out_byte_ff <= s1_byte_ff;
         out_last_ff <= done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// ----- rtl/delimiter_or_length_framer.sv -----
// Top level of the delimiter or fixed length byte framer.
//
// channel  direction  payload
// req_     in         tdata[7:0] data_byte
// rsp_     out        tdata[7:0] out_byte, tlast frame_end
// csr_     in         index[2:0] register, data[63:0] value
//
// One item per cycle sustained while rsp is ready; an item is taken into the input
// register and then passes through the result register to rsp.
// The delimiter compare over the eight-byte window sits between those two.
// Reset is synchronous: frame progress cleared, registers to defaults.
// A stalled rsp holds its item; req stays ready while the input stage can drain.
// csr_ready is always high; every write to a listed register clears progress.
`default_nettype none
module delimiter_or_length_framer (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [dlf_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] data_byte
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [dlf_pkg::BYTE_W-1:0]   rsp_tdata,   // [7:0] out_byte
   output logic                         rsp_tlast,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [dlf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [dlf_pkg::WIN_W-1:0]     csr_data
);
   import dlf_pkg::*;

   cfg_type cfg;
   logic    clear;

   assign csr_ready = 1'b1;

   dlf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .clear     (clear)
   );

   dlf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .clear      (clear),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- rtl/dlf_checker.sv -----
// Port-level checks of the framer, bound to the top level.
`default_nettype none
`include "delimiter_or_length_framer_assert.svh"
module dlf_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_tvalid,
   input wire                          req_tready,
   input wire                          rsp_tvalid,
   input wire                          rsp_tready,
   input wire [dlf_pkg::BYTE_W-1:0]    rsp_tdata,
   input wire                          rsp_tlast,
   input wire                          csr_valid,
   input wire                          csr_ready
);
   import dlf_pkg::*;

   logic       in_acc;
   logic       out_acc;
   logic [1:0] flight_ff, flight_in;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      flight_in = flight_ff;
      if (in_acc && !out_acc) begin
         flight_in = flight_ff + 2'd1;
      end else if (!in_acc && out_acc) begin
         flight_in = flight_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   `DLF_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp item changed while stalled")
   `DLF_ASSERT_IMP(a_depth, 1'b1, (flight_ff != 2'd3), "more than two items in flight")
   `DLF_ASSERT_IMP(a_no_invent, rsp_tvalid, (flight_ff != 2'd0), "result with no item in flight")
   `DLF_ASSERT_IMP(a_latency, in_acc && flight_ff == 2'd0, ##2 rsp_tvalid, "item not shown two cycles after an empty pipe")
   `DLF_ASSERT_IMP(a_csr_ready, csr_valid, csr_ready, "csr write refused")

endmodule

bind delimiter_or_length_framer dlf_checker u_dlf_checker (.*);
`default_nettype wire
